>>> design/knt_pkg.sv
package knt_pkg;

  typedef enum logic [3:0] {
    KIND_EOS    = 4'd0,
    KIND_LBRK   = 4'd1,
    KIND_RBRK   = 4'd2,
    KIND_COMMA  = 4'd3,
    KIND_COLON  = 4'd4,
    KIND_EQUAL  = 4'd5,
    KIND_BEGIN  = 4'd6,
    KIND_ACTION = 4'd7,
    KIND_NUMBER = 4'd8,
    KIND_ERROR  = 4'd9
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [31:0] value;
    logic [15:0] line;
    logic        last;
  } tok_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;
  localparam int FIFO_CW    = 3;

  localparam int KW_BEGIN_LEN  = 5;
  localparam int KW_ACTION_LEN = 6;

  localparam logic [7:0] KW_BEGIN  [KW_BEGIN_LEN]  = '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6e};
  localparam logic [7:0] KW_ACTION [KW_ACTION_LEN] = '{8'h61, 8'h63, 8'h74, 8'h69, 8'h6f, 8'h6e};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_RBRK   = 8'h5d;

endpackage

>>> design/keyword_number_tokenizer.sv
// channel  | ports                              | contents
// in       | in_tvalid in_tready in_tdata[7:0]  | text_byte
// out      | out_tvalid out_tready out_tdata    | number_value, line_number in tdata;
//          | out_tuser[3:0] out_tlast           | token_kind in tuser; last_of_item in tlast
//
// one byte per cycle: input register, one pass of scan logic, 4-entry token queue
// a byte is scanned once the queue has room for two tokens, so a byte giving two
// tokens is taken in with one input handshake and leaves as two output tokens
// byte path to out: input register, scan logic, then the token queue
// rst_n is synchronous, active low; it clears scan state and line count to 1
// out stalls fill the queue and then hold in_tready low
module keyword_number_tokenizer #(
  parameter int MAX_TOKEN_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] number_value, [47:32] line_number
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast
);

  localparam int RUN_W = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_WORD    = 3'd1,
    M_NUM     = 3'd2,
    M_SIGN    = 3'd3,
    M_COMMENT = 3'd4,
    M_ERROR   = 3'd5
  } mode_t;

  // input register
  logic       byte_vld_r;
  logic [7:0] byte_r;

  // scan state
  mode_t            mode_r,  mode_nxt;
  logic [2:0]       prog_r,  prog_nxt;
  logic [1:0]       cand_r,  cand_nxt;
  logic [RUN_W-1:0] run_r,   run_nxt;
  logic [31:0]      acc_r,   acc_nxt;
  logic             neg_r,   neg_nxt;
  logic [15:0]      line_r,  line_nxt;

  // token queue
  knt_pkg::tok_t              fifo_r [knt_pkg::FIFO_DEPTH];
  logic [knt_pkg::FIFO_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [knt_pkg::FIFO_CW-1:0] count_r;

  logic consume, pop;
  logic [1:0] push_cnt;

  logic              a_vld, b_vld;
  knt_pkg::tok_kind_t a_kind, b_kind;
  logic [31:0]       a_val;

  logic              pend_vld;
  knt_pkg::tok_kind_t pend_kind;
  logic [31:0]       pend_val;

  logic [7:0] lower;
  logic is_letter, is_digit, is_space;
  logic [3:0] dig;
  logic [4:0] let_cont, let_fresh;
  logic [31:0] dig_cont, dig_fresh;
  logic [15:0] line_inc;

  knt_pkg::tok_t tok_a, tok_b;

  function automatic logic [4:0] add_letter(input logic [2:0] p, input logic [1:0] c,
                                            input logic [7:0] ch);
    logic [1:0] cn;
    logic [2:0] pn;
    cn = c;
    if (!(p < 3'(knt_pkg::KW_BEGIN_LEN) && knt_pkg::KW_BEGIN[p] == ch)) cn[0] = 1'b0;
    if (!(p < 3'(knt_pkg::KW_ACTION_LEN) && knt_pkg::KW_ACTION[p] == ch)) cn[1] = 1'b0;
    pn = (p != 3'd7) ? p + 3'd1 : p;
    return {pn, cn};
  endfunction

  function automatic logic [31:0] add_digit(input logic [31:0] a, input logic [3:0] d);
    logic [35:0] t;
    t = {a, 3'b000} + {3'b000, a, 1'b0} + {32'd0, d};
    if (t > 36'h0_8000_0000) t = 36'h0_8000_0000;
    return t[31:0];
  endfunction

  assign consume   = byte_vld_r && (count_r <= knt_pkg::FIFO_CW'(knt_pkg::FIFO_DEPTH - 2));
  assign in_tready = !byte_vld_r || consume;
  assign pop       = out_tvalid && out_tready;

  assign lower     = (byte_r >= 8'h41 && byte_r <= 8'h5a) ? byte_r + 8'd32 : byte_r;
  assign is_letter = lower >= 8'h61 && lower <= 8'h7a;
  assign is_digit  = byte_r >= 8'h30 && byte_r <= 8'h39;
  assign is_space  = byte_r == knt_pkg::CH_SPACE || (byte_r >= 8'd9 && byte_r <= 8'd13);
  assign dig       = byte_r[3:0];
  assign let_cont  = add_letter(prog_r, cand_r, lower);
  assign let_fresh = add_letter(3'd0, 2'b11, lower);
  assign dig_cont  = add_digit(acc_r, dig);
  assign dig_fresh = add_digit(32'd0, dig);
  assign line_inc  = (line_r != 16'hffff) ? line_r + 16'd1 : line_r;

  // token held by the current run
  always_comb begin
    pend_vld  = 1'b0;
    pend_kind = knt_pkg::KIND_ERROR;
    pend_val  = 32'd0;
    case (mode_r)
      M_WORD: begin
        pend_vld = 1'b1;
        if (cand_r[0] && run_r == RUN_W'(knt_pkg::KW_BEGIN_LEN)) begin
          pend_kind = knt_pkg::KIND_BEGIN;
        end else if (cand_r[1] && run_r == RUN_W'(knt_pkg::KW_ACTION_LEN)) begin
          pend_kind = knt_pkg::KIND_ACTION;
        end
      end
      M_NUM: begin
        pend_vld  = 1'b1;
        pend_kind = knt_pkg::KIND_NUMBER;
        if (neg_r) pend_val = 32'd0 - acc_r;
        else       pend_val = acc_r[31] ? 32'h7fff_ffff : acc_r;
      end
      M_SIGN: pend_vld = 1'b1;
      default: pend_vld = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    prog_nxt = prog_r;
    cand_nxt = cand_r;
    run_nxt  = run_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    line_nxt = line_r;
    a_vld    = 1'b0;
    a_kind   = knt_pkg::KIND_EOS;
    a_val    = 32'd0;
    b_vld    = 1'b0;
    b_kind   = knt_pkg::KIND_EOS;
    if (consume) begin
      if (byte_r == knt_pkg::CH_NUL) begin
        if (mode_r != M_ERROR) begin
          a_vld  = pend_vld;
          a_kind = pend_kind;
          a_val  = pend_val;
        end
        b_vld    = 1'b1;
        b_kind   = knt_pkg::KIND_EOS;
        mode_nxt = M_IDLE;
        prog_nxt = 3'd0;
        cand_nxt = 2'b11;
        run_nxt  = '0;
        acc_nxt  = 32'd0;
        neg_nxt  = 1'b0;
        line_nxt = 16'd1;
      end else if (mode_r == M_ERROR) begin
        mode_nxt = M_ERROR;
      end else if (mode_r == M_COMMENT) begin
        if (byte_r == knt_pkg::CH_NL) begin
          line_nxt = line_inc;
          mode_nxt = M_IDLE;
        end
      end else if (mode_r == M_SIGN && is_digit) begin
        mode_nxt = M_NUM;
        acc_nxt  = dig_cont;
        run_nxt  = run_r + RUN_W'(1);
      end else if (mode_r == M_SIGN) begin
        b_vld    = 1'b1;
        b_kind   = knt_pkg::KIND_ERROR;
        mode_nxt = M_ERROR;
        run_nxt  = '0;
        acc_nxt  = 32'd0;
        neg_nxt  = 1'b0;
      end else if (mode_r == M_WORD && is_letter && run_r < RUN_W'(MAX_TOKEN_LEN)) begin
        {prog_nxt, cand_nxt} = let_cont;
        run_nxt = run_r + RUN_W'(1);
      end else if (mode_r == M_NUM && is_digit && run_r < RUN_W'(MAX_TOKEN_LEN)) begin
        acc_nxt = dig_cont;
        run_nxt = run_r + RUN_W'(1);
      end else begin
        // close the current run, then classify the byte
        a_vld    = pend_vld;
        a_kind   = pend_kind;
        a_val    = pend_val;
        mode_nxt = M_IDLE;
        prog_nxt = 3'd0;
        cand_nxt = 2'b11;
        run_nxt  = '0;
        acc_nxt  = 32'd0;
        neg_nxt  = 1'b0;
        if (pend_vld && pend_kind == knt_pkg::KIND_ERROR) begin
          mode_nxt = M_ERROR;
        end else if (is_space) begin
          if (byte_r == knt_pkg::CH_NL) line_nxt = line_inc;
        end else if (byte_r == knt_pkg::CH_SEMI) begin
          mode_nxt = M_COMMENT;
        end else if (byte_r == knt_pkg::CH_LBRK) begin
          b_vld  = 1'b1;
          b_kind = knt_pkg::KIND_LBRK;
        end else if (byte_r == knt_pkg::CH_RBRK) begin
          b_vld  = 1'b1;
          b_kind = knt_pkg::KIND_RBRK;
        end else if (byte_r == knt_pkg::CH_COMMA) begin
          b_vld  = 1'b1;
          b_kind = knt_pkg::KIND_COMMA;
        end else if (byte_r == knt_pkg::CH_COLON) begin
          b_vld  = 1'b1;
          b_kind = knt_pkg::KIND_COLON;
        end else if (byte_r == knt_pkg::CH_EQUAL) begin
          b_vld  = 1'b1;
          b_kind = knt_pkg::KIND_EQUAL;
        end else if (is_letter) begin
          mode_nxt = M_WORD;
          {prog_nxt, cand_nxt} = let_fresh;
          run_nxt  = RUN_W'(1);
        end else if (is_digit) begin
          mode_nxt = M_NUM;
          acc_nxt  = dig_fresh;
          run_nxt  = RUN_W'(1);
        end else if (byte_r == knt_pkg::CH_PLUS || byte_r == knt_pkg::CH_MINUS) begin
          mode_nxt = M_SIGN;
          neg_nxt  = byte_r == knt_pkg::CH_MINUS;
          run_nxt  = RUN_W'(1);
        end else begin
          b_vld    = 1'b1;
          b_kind   = knt_pkg::KIND_ERROR;
          mode_nxt = M_ERROR;
        end
      end
    end
  end

  assign push_cnt = {1'b0, a_vld} + {1'b0, b_vld};

  always_comb begin
    tok_a.kind  = a_kind;
    tok_a.value = a_val;
    tok_a.line  = line_r;
    tok_a.last  = !b_vld;
    tok_b.kind  = b_kind;
    tok_b.value = 32'd0;
    tok_b.line  = line_r;
    tok_b.last  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      mode_r     <= M_IDLE;
      prog_r     <= 3'd0;
      cand_r     <= 2'b11;
      run_r      <= '0;
      acc_r      <= 32'd0;
      neg_r      <= 1'b0;
      line_r     <= 16'd1;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      if (in_tready) byte_vld_r <= in_tvalid;
      mode_r   <= mode_nxt;
      prog_r   <= prog_nxt;
      cand_r   <= cand_nxt;
      run_r    <= run_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      line_r   <= line_nxt;
      wr_ptr_r <= wr_ptr_r + knt_pkg::FIFO_PW'(push_cnt);
      rd_ptr_r <= rd_ptr_r + knt_pkg::FIFO_PW'(pop);
      count_r  <= count_r + knt_pkg::FIFO_CW'(push_cnt) - knt_pkg::FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) byte_r <= in_tdata;
    if (a_vld) begin
      fifo_r[wr_ptr_r] <= tok_a;
      if (b_vld) fifo_r[wr_ptr_r + knt_pkg::FIFO_PW'(1)] <= tok_b;
    end else if (b_vld) begin
      fifo_r[wr_ptr_r] <= tok_b;
    end
  end

  assign out_tvalid = count_r != '0;
  assign out_tdata  = {fifo_r[rd_ptr_r].line, fifo_r[rd_ptr_r].value};
  assign out_tuser  = fifo_r[rd_ptr_r].kind;
  assign out_tlast  = fifo_r[rd_ptr_r].last;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= knt_pkg::FIFO_CW'(knt_pkg::FIFO_DEPTH))
    else $error("token queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> count_r <= knt_pkg::FIFO_CW'(knt_pkg::FIFO_DEPTH - 2))
    else $error("token pushed without room");

  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    consume && mode_r == M_ERROR && byte_r != knt_pkg::CH_NUL |-> push_cnt == 2'd0)
    else $error("token emitted after error");

  a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
    consume && byte_r == knt_pkg::CH_NUL |=> mode_r == M_IDLE && line_r == 16'd1)
    else $error("end of text did not restore scan state");

  a_error_enters: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld && b_kind == knt_pkg::KIND_ERROR |=> mode_r == M_ERROR)
    else $error("error token without error mode");
`endif

endmodule

>>> dv/token_checker.sv
`timescale 1ns / 100ps
module token_checker
  import knt_pkg::*;
#(
  parameter int RUN_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [31:0] number_value, [47:32] line_number
  input  logic [3:0]  out_tuser,  // [3:0] token_kind
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count
);

  typedef enum logic [2:0] {
    LEX_IDLE,
    LEX_WORD,
    LEX_NUMBER,
    LEX_SIGN,
    LEX_COMMENT,
    LEX_ERROR
  } lex_mode_t;

  lex_mode_t   lex_mode;
  logic [2:0]  kw_len;
  logic [1:0]  kw_match;  // bit0 begin, bit1 action
  int          run_len;
  logic [31:0] magnitude;
  logic        negative;
  logic [15:0] line_no;
  tok_t        expected_tokens[$];
  tok_t        byte_tokens[2];
  int          byte_token_cnt;
  int          mismatches = 0;
  int          waiting = 0;

  assign fail_count    = mismatches;
  assign pending_count = waiting;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < 40) begin
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic clear_run();
    kw_len    = '0;
    kw_match  = 2'b11;
    run_len   = 0;
    magnitude = '0;
    negative  = 1'b0;
  endtask

  task automatic restart();
    lex_mode = LEX_IDLE;
    clear_run();
    line_no = 16'd1;
  endtask

  task automatic bump_line();
    if (line_no != 16'hffff) line_no++;
  endtask

  task automatic emit(input tok_kind_t kind, input logic [31:0] value);
    byte_tokens[byte_token_cnt] = '{kind: kind, value: value, line: line_no, last: 1'b0};
    byte_token_cnt++;
  endtask

  task automatic add_letter(input logic [7:0] b);
    logic [7:0] c;
    c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (kw_len >= KW_BEGIN_LEN || KW_BEGIN[kw_len] != c) kw_match[0] = 1'b0;
    if (kw_len >= KW_ACTION_LEN || KW_ACTION[kw_len] != c) kw_match[1] = 1'b0;
    if (kw_len != 3'd7) kw_len++;
    run_len++;
  endtask

  task automatic add_digit(input logic [7:0] b);
    logic [63:0] t;
    t = 64'(magnitude) * 64'd10 + 64'(b - 8'h30);
    if (t > 64'h8000_0000) t = 64'h8000_0000;
    magnitude = t[31:0];
    run_len++;
  endtask

  function automatic logic [31:0] signed_value();
    if (negative) return (magnitude >= 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - magnitude;
    return (magnitude > 32'h7fff_ffff) ? 32'h7fff_ffff : magnitude;
  endfunction

  // pending word, number or sign is closed out
  task automatic finish_pending(output logic err);
    err = 1'b0;
    case (lex_mode)
      LEX_WORD: begin
        if (kw_match[0] && run_len == KW_BEGIN_LEN) emit(KIND_BEGIN, '0);
        else if (kw_match[1] && run_len == KW_ACTION_LEN) emit(KIND_ACTION, '0);
        else begin
          emit(KIND_ERROR, '0);
          err = 1'b1;
        end
      end
      LEX_NUMBER: emit(KIND_NUMBER, signed_value());
      LEX_SIGN: begin
        emit(KIND_ERROR, '0);
        err = 1'b1;
      end
      default: ;
    endcase
    if (lex_mode != LEX_COMMENT) lex_mode = LEX_IDLE;
    clear_run();
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic err;
    byte_token_cnt = 0;
    if (b == CH_NUL) begin
      if (lex_mode != LEX_ERROR) finish_pending(err);
      emit(KIND_EOS, '0);
      restart();
    end else if (lex_mode == LEX_ERROR) begin
      // ignored until end of text
    end else if (lex_mode == LEX_COMMENT) begin
      if (b == CH_NL) begin
        bump_line();
        lex_mode = LEX_IDLE;
      end
    end else if (lex_mode == LEX_SIGN && is_digit(b)) begin
      lex_mode = LEX_NUMBER;
      add_digit(b);
    end else if (lex_mode == LEX_SIGN) begin
      emit(KIND_ERROR, '0);
      lex_mode = LEX_ERROR;
      clear_run();
    end else if (lex_mode == LEX_WORD && is_letter(b) && run_len < RUN_LIMIT) begin
      add_letter(b);
    end else if (lex_mode == LEX_NUMBER && is_digit(b) && run_len < RUN_LIMIT) begin
      add_digit(b);
    end else begin
      finish_pending(err);
      if (err) lex_mode = LEX_ERROR;
      else if (is_space(b)) begin
        if (b == CH_NL) bump_line();
      end else if (b == CH_SEMI) lex_mode = LEX_COMMENT;
      else if (b == CH_LBRK) emit(KIND_LBRK, '0);
      else if (b == CH_RBRK) emit(KIND_RBRK, '0);
      else if (b == CH_COMMA) emit(KIND_COMMA, '0);
      else if (b == CH_COLON) emit(KIND_COLON, '0);
      else if (b == CH_EQUAL) emit(KIND_EQUAL, '0);
      else if (is_letter(b)) begin
        lex_mode = LEX_WORD;
        add_letter(b);
      end else if (is_digit(b)) begin
        lex_mode = LEX_NUMBER;
        add_digit(b);
      end else if (b == CH_PLUS || b == CH_MINUS) begin
        lex_mode = LEX_SIGN;
        negative = (b == CH_MINUS);
        run_len  = 1;
      end else begin
        emit(KIND_ERROR, '0);
        lex_mode = LEX_ERROR;
      end
    end
    if (byte_token_cnt > 0) byte_tokens[byte_token_cnt - 1].last = 1'b1;
    for (int i = 0; i < byte_token_cnt; i++) expected_tokens.push_back(byte_tokens[i]);
  endtask

  task automatic check_token();
    tok_t want;
    if (expected_tokens.size() == 0) begin
      report("unexpected token, kind", 32'(out_tuser), '0);
      return;
    end
    want = expected_tokens.pop_front();
    if (out_tuser !== want.kind) report("token_kind", 32'(out_tuser), 32'(want.kind));
    if (out_tdata[31:0] !== want.value) report("number_value", out_tdata[31:0], want.value);
    if (out_tdata[47:32] !== want.line) report("line_number", 32'(out_tdata[47:32]), 32'(want.line));
    if (out_tlast !== want.last) report("last_of_item", 32'(out_tlast), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart();
      expected_tokens.delete();
    end else begin
      if (out_tvalid && out_tready) check_token();
      if (in_tvalid && in_tready) predict_byte(in_tdata);
    end
    waiting = expected_tokens.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
module tb;
  import knt_pkg::*;

  localparam int TOKEN_LEN   = 256;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_BYTES = 160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending_count;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          quiet_cycles = 0;
  int          sent_bytes = 0;
  logic [7:0]  text_bytes[$];

  always #6 clk = ~clk;

  keyword_number_tokenizer #(
    .MAX_TOKEN_LEN(TOKEN_LEN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  token_checker #(
    .RUN_LIMIT(TOKEN_LEN)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // token sink, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i]);
    text_bytes.delete();
  endtask

  // no new request until every token is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  task automatic put_run(input logic [7:0] c, input int n);
    repeat (n) text_bytes.push_back(c);
  endtask

  task automatic put_keyword();
    string w;
    logic [7:0] c;
    w = $urandom_range(1) ? "begin" : "action";
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if ($urandom_range(1)) c = c - 8'd32;
      text_bytes.push_back(c);
    end
  endtask

  task automatic put_number();
    case ($urandom_range(2))
      1: text_bytes.push_back(CH_PLUS);
      2: text_bytes.push_back(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(9))
      0: put_str("2147483647");
      1: put_str("2147483648");
      2: put_str("2147483649");
      3: put_str("99999999999");
      4: put_str("0");
      default: repeat ($urandom_range(1, 9)) text_bytes.push_back(8'h30 + 8'($urandom_range(9)));
    endcase
  endtask

  task automatic put_delim();
    case ($urandom_range(4))
      0: text_bytes.push_back(CH_LBRK);
      1: text_bytes.push_back(CH_RBRK);
      2: text_bytes.push_back(CH_COMMA);
      3: text_bytes.push_back(CH_COLON);
      default: text_bytes.push_back(CH_EQUAL);
    endcase
  endtask

  task automatic put_gap();
    logic [7:0] c;
    case ($urandom_range(7))
      0: text_bytes.push_back(CH_NL);
      1: text_bytes.push_back(8'd9);
      2: text_bytes.push_back(8'($urandom_range(11, 13)));
      3: begin
        text_bytes.push_back(CH_SEMI);
        repeat ($urandom_range(6)) begin
          c = 8'($urandom_range(1, 254));
          if (c >= CH_NL) c++;
          text_bytes.push_back(c);
        end
        text_bytes.push_back(CH_NL);
      end
      default: text_bytes.push_back(CH_SPACE);
    endcase
  endtask

  task automatic put_noise();
    case ($urandom_range(2))
      0: text_bytes.push_back(8'($urandom_range(1, 255)));
      1: repeat ($urandom_range(1, 7)) text_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
      default: begin
        text_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        text_bytes.push_back(CH_SPACE);
      end
    endcase
  endtask

  // mostly well-formed token streams, a little noise
  task automatic make_text();
    int prev_cat;
    int cat;
    int pick;
    prev_cat = -1;
    repeat ($urandom_range(2, 14)) begin
      pick = $urandom_range(99);
      cat = (pick < 35) ? 0 : (pick < 60) ? 1 : (pick < 96) ? 2 : 3;
      if ((cat == prev_cat && cat != 0) || $urandom_range(1)) put_gap();
      case (cat)
        0: put_delim();
        1: put_keyword();
        2: put_number();
        default: put_noise();
      endcase
      prev_cat = cat;
    end
    if ($urandom_range(1)) put_gap();
    text_bytes.push_back(CH_NUL);
  endtask

  task automatic random_phase(input int tx_pct, input int rx_pct);
    int phase_start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    phase_start = sent_bytes;
    while (sent_bytes - phase_start < PHASE_BYTES) begin
      make_text();
      send_text();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_idle_pct = 22;
    rx_idle_pct = 59;

    put_str("[],:=Begin\tACTION-7\n12;note [\n");
    put_run(8'd11, 1);
    put_run(8'd12, 1);
    put_run(8'd13, 1);
    put_str("=action");
    text_bytes.push_back(CH_NUL);
    put_str("-2147483649 +2147483648 4294967296,-2147483648 2147483647");
    text_bytes.push_back(CH_NUL);
    put_str("+x[\n");
    text_bytes.push_back(CH_NUL);
    put_str("beginx [");
    text_bytes.push_back(CH_NUL);
    text_bytes.push_back(8'h80);
    text_bytes.push_back(CH_NUL);
    text_bytes.push_back(8'hff);
    text_bytes.push_back(CH_NUL);
    put_str("7-");
    text_bytes.push_back(CH_NUL);
    text_bytes.push_back(CH_NUL);
    // runs past the length limit
    text_bytes.push_back(CH_MINUS);
    put_run("0", 298);
    put_str("12");
    text_bytes.push_back(CH_NUL);
    put_run("z", 260);
    text_bytes.push_back(CH_NUL);
    send_text();
    drain();

    random_phase(22, 59);
    random_phase(59, 22);
    hold_req = 1'b1;
    random_phase(0, 0);

    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
